// ===== design/bsbz_pkg.sv =====
`default_nettype none

package bsbz_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned SumW      = 35;  // six times a coordinate, signed
  localparam int unsigned HalfW     = 33;  // (|sum| + 3) / 2
  localparam int unsigned HiW       = 17;
  localparam int unsigned LoW       = 16;
  localparam int unsigned RemW      = 18;
  localparam int unsigned ProdHiW   = 32;
  localparam int unsigned ProdRemW  = 36;
  localparam int unsigned QuotW     = 33;
  // 2^16 = 3 * 21845 + 1, so x / 3 = hi * 21845 + (hi + lo) / 3
  localparam int unsigned Third16   = 21845;
  // ceil(2^19 / 3), exact for the remainder range
  localparam int unsigned Recip3    = 174763;
  localparam int unsigned RecipSh   = 19;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);
  localparam int unsigned DataW      = 2 * CoordW;

  // which weighted sum a result uses, in emission order
  typedef enum logic [1:0] {
    PH_OUTER  = 2'd0,  // a + 4b + c
    PH_NEAR_B = 2'd1,  // 4b + 2c
    PH_NEAR_C = 2'd2,  // 2b + 4c
    PH_JOIN   = 2'd3   // b + 4c + d
  } phase_e;

  typedef enum logic {
    FS_ACCEPT,
    FS_REPLAY
  } front_state_e;

  typedef struct packed {
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
  } point_t;

  // one segment job: four results from PH_OUTER, three from PH_NEAR_B, one from PH_JOIN
  typedef struct packed {
    phase_e start;
    logic   last;
    logic   err;
    point_t a;
    point_t b;
    point_t c;
    point_t d;
  } job_t;

endpackage

`default_nettype wire

// ===== design/bsbz_front.sv =====
`default_nettype none

module bsbz_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire bsbz_pkg::point_t in_point_i,
  input  wire logic            in_last_i,
  input  wire logic            cfg_valid_i,
  input  wire logic            cfg_data_i,
  output logic                 push_o,
  output bsbz_pkg::job_t       job_o,
  input  wire logic            full_i
);

  bsbz_pkg::front_state_e state_q, state_d;
  logic [2:0]             cnt_q, cnt_d;
  logic                   closed_q;
  logic [1:0]             ridx_q, ridx_d;
  bsbz_pkg::point_t       win_q [3];
  bsbz_pkg::point_t       win_d [3];
  bsbz_pkg::point_t       head_q [3];
  bsbz_pkg::point_t       head_d [3];
  bsbz_pkg::point_t       ws [3];
  logic                   acc;
  logic                   start_replay;

  assign acc = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bsbz_pkg::FS_ACCEPT: begin
        if (start_replay) state_d = bsbz_pkg::FS_REPLAY;
      end
      bsbz_pkg::FS_REPLAY: begin
        if (!full_i && ridx_q == 2'd2) state_d = bsbz_pkg::FS_ACCEPT;
      end
      default: state_d = bsbz_pkg::FS_ACCEPT;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready_o = 1'b0;
    unique case (state_q)
      bsbz_pkg::FS_ACCEPT: in_ready_o = !full_i;
      bsbz_pkg::FS_REPLAY: in_ready_o = 1'b0;
      default:             in_ready_o = 1'b0;
    endcase
  end

  // classification and window bookkeeping
  always_comb begin
    push_o       = 1'b0;
    job_o        = '0;
    cnt_d        = cnt_q;
    ridx_d       = ridx_q;
    start_replay = 1'b0;
    win_d        = win_q;
    head_d       = head_q;
    ws[0]        = win_q[1];
    ws[1]        = win_q[2];
    ws[2]        = in_point_i;
    if (state_q == bsbz_pkg::FS_REPLAY) begin
      if (!full_i) begin
        push_o      = 1'b1;
        job_o.start = bsbz_pkg::PH_NEAR_B;
        job_o.last  = (ridx_q == 2'd2);
        job_o.b     = win_q[1];
        job_o.c     = win_q[2];
        job_o.d     = head_q[ridx_q];
        win_d[0]    = win_q[1];
        win_d[1]    = win_q[2];
        win_d[2]    = head_q[ridx_q];
        ridx_d      = ridx_q + 2'd1;
      end
    end else if (acc) begin
      priority if (cnt_q < 3'd2) begin
        if (in_last_i) begin
          // run too short: one flagged all-zero result
          push_o      = 1'b1;
          job_o.start = bsbz_pkg::PH_JOIN;
          job_o.last  = 1'b1;
          job_o.err   = 1'b1;
          cnt_d       = 3'd0;
        end else begin
          head_d[cnt_q[1:0]] = in_point_i;
          win_d              = ws;
          cnt_d              = cnt_q + 3'd1;
        end
      end else if (cnt_q == 3'd2) begin
        head_d[2] = in_point_i;
        if (!in_last_i) begin
          win_d = ws;
          cnt_d = 3'd3;
        end else begin
          // three-point run: the first point stands in as the fourth
          push_o      = 1'b1;
          job_o.start = bsbz_pkg::PH_OUTER;
          job_o.last  = !closed_q;
          job_o.a     = ws[0];
          job_o.b     = ws[1];
          job_o.c     = ws[2];
          job_o.d     = head_q[0];
          win_d[0]    = ws[1];
          win_d[1]    = ws[2];
          win_d[2]    = head_q[0];
          cnt_d       = 3'd0;
          ridx_d      = 2'd1;
          start_replay = closed_q;
        end
      end else begin
        push_o      = 1'b1;
        job_o.start = (cnt_q == 3'd3) ? bsbz_pkg::PH_OUTER : bsbz_pkg::PH_NEAR_B;
        job_o.last  = in_last_i && !closed_q;
        job_o.a     = win_q[0];
        job_o.b     = win_q[1];
        job_o.c     = win_q[2];
        job_o.d     = in_point_i;
        win_d       = ws;
        cnt_d       = in_last_i ? 3'd0 : 3'd4;
        ridx_d      = 2'd0;
        start_replay = in_last_i && closed_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bsbz_pkg::FS_ACCEPT;
      cnt_q    <= 3'd0;
      closed_q <= 1'b0;
      ridx_q   <= 2'd0;
      win_q    <= '{default: '0};
      head_q   <= '{default: '0};
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ridx_q  <= ridx_d;
      win_q   <= win_d;
      head_q  <= head_d;
      if (cfg_valid_i) begin
        closed_q <= cfg_data_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/bsbz_queue.sv =====
`default_nettype none

module bsbz_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire bsbz_pkg::job_t push_job_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output bsbz_pkg::job_t      head_job_o,
  output logic                empty_o
);

  bsbz_pkg::job_t                   mem_q [bsbz_pkg::QueueDepth];
  logic [bsbz_pkg::QueuePtrW-1:0]   wptr_q, rptr_q;
  logic [bsbz_pkg::QueueCntW-1:0]   count_q;

  assign full_o     = (count_q == bsbz_pkg::QueueCntW'(bsbz_pkg::QueueDepth));
  assign empty_o    = (count_q == '0);
  assign head_job_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("job pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("job popped from an empty queue");
`endif

endmodule

`default_nettype wire

// ===== design/bsbz_back.sv =====
`default_nettype none

module bsbz_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bsbz_pkg::job_t              job_i,
  input  wire logic                        empty_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [bsbz_pkg::DataW-1:0]       out_data_o,
  output logic                             out_last_o,
  output logic                             out_user_o
);

  localparam int unsigned SumW   = bsbz_pkg::SumW;
  localparam int unsigned HalfW  = bsbz_pkg::HalfW;
  localparam int unsigned LoW    = bsbz_pkg::LoW;
  localparam int unsigned RemW   = bsbz_pkg::RemW;
  localparam int unsigned PHiW   = bsbz_pkg::ProdHiW;
  localparam int unsigned PRemW  = bsbz_pkg::ProdRemW;
  localparam int unsigned QuotW  = bsbz_pkg::QuotW;
  localparam int unsigned CoordW = bsbz_pkg::CoordW;

  function automatic logic signed [SumW-1:0] weighted(
    input bsbz_pkg::phase_e       ph,
    input logic signed [CoordW-1:0] a,
    input logic signed [CoordW-1:0] b,
    input logic signed [CoordW-1:0] c,
    input logic signed [CoordW-1:0] d
  );
    logic signed [SumW-1:0] ea, eb, ec, ed, r;
    ea = SumW'(a);
    eb = SumW'(b);
    ec = SumW'(c);
    ed = SumW'(d);
    unique case (ph)
      bsbz_pkg::PH_OUTER:  r = ea + (eb <<< 2) + ec;
      bsbz_pkg::PH_NEAR_B: r = (eb <<< 2) + (ec <<< 1);
      bsbz_pkg::PH_NEAR_C: r = (eb <<< 1) + (ec <<< 2);
      bsbz_pkg::PH_JOIN:   r = eb + (ec <<< 2) + ed;
      default:             r = '0;
    endcase
    return r;
  endfunction

  // (|s| + 3) >> 1, so that the quotient by three rounds to nearest
  function automatic logic [HalfW-1:0] half_mag(input logic signed [SumW-1:0] s);
    logic [SumW-1:0] m;
    m = s[SumW-1] ? SumW'(-s) : SumW'(s);
    m = m + SumW'(3);
    return m[HalfW:1];
  endfunction

  function automatic logic [CoordW-1:0] finish(
    input logic [PHiW-1:0]  p_hi,
    input logic [PRemW-1:0] p_rem,
    input logic             neg
  );
    logic [QuotW-1:0] q;
    q = QuotW'(p_hi) + QuotW'(p_rem >> bsbz_pkg::RecipSh);
    if (neg) q = -q;
    return q[CoordW-1:0];
  endfunction

  logic                pipe_en, adv;
  logic                busy_q;
  bsbz_pkg::phase_e    phase_q, cur_phase;

  logic                   s1_valid_q, s1_last_q, s1_err_q;
  logic signed [SumW-1:0] s1_sx_q, s1_sy_q;
  logic                   s2_valid_q, s2_last_q, s2_err_q, s2_nx_q, s2_ny_q;
  logic [HalfW-1:0]       s2_mx_q, s2_my_q;
  logic                   s3_valid_q, s3_last_q, s3_err_q, s3_nx_q, s3_ny_q;
  logic [PHiW-1:0]        s3_hx_q, s3_hy_q;
  logic [PRemW-1:0]       s3_rx_q, s3_ry_q;
  logic [RemW-1:0]        rem_x, rem_y;

  assign pipe_en   = !out_valid_o || out_ready_i;
  assign adv       = pipe_en && !empty_i;
  assign cur_phase = busy_q ? phase_q : job_i.start;
  assign pop_o     = adv && (cur_phase == bsbz_pkg::PH_JOIN);

  assign rem_x = RemW'(s2_mx_q[HalfW-1:LoW]) + RemW'(s2_mx_q[LoW-1:0]);
  assign rem_y = RemW'(s2_my_q[HalfW-1:LoW]) + RemW'(s2_my_q[LoW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= bsbz_pkg::PH_OUTER;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (pipe_en) begin
      if (adv) begin
        busy_q  <= (cur_phase != bsbz_pkg::PH_JOIN);
        phase_q <= bsbz_pkg::phase_e'(cur_phase + 2'd1);
      end
      s1_valid_q  <= adv;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_o <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_sx_q   <= weighted(cur_phase, job_i.a.x, job_i.b.x, job_i.c.x, job_i.d.x);
      s1_sy_q   <= weighted(cur_phase, job_i.a.y, job_i.b.y, job_i.c.y, job_i.d.y);
      s1_last_q <= job_i.last && (cur_phase == bsbz_pkg::PH_JOIN);
      s1_err_q  <= job_i.err;

      s2_mx_q   <= half_mag(s1_sx_q);
      s2_my_q   <= half_mag(s1_sy_q);
      s2_nx_q   <= s1_sx_q[SumW-1];
      s2_ny_q   <= s1_sy_q[SumW-1];
      s2_last_q <= s1_last_q;
      s2_err_q  <= s1_err_q;

      s3_hx_q   <= PHiW'(s2_mx_q[HalfW-1:LoW]) * PHiW'(bsbz_pkg::Third16);
      s3_hy_q   <= PHiW'(s2_my_q[HalfW-1:LoW]) * PHiW'(bsbz_pkg::Third16);
      s3_rx_q   <= PRemW'(rem_x) * PRemW'(bsbz_pkg::Recip3);
      s3_ry_q   <= PRemW'(rem_y) * PRemW'(bsbz_pkg::Recip3);
      s3_nx_q   <= s2_nx_q;
      s3_ny_q   <= s2_ny_q;
      s3_last_q <= s2_last_q;
      s3_err_q  <= s2_err_q;

      out_data_o <= {finish(s3_hy_q, s3_ry_q, s3_ny_q), finish(s3_hx_q, s3_rx_q, s3_nx_q)};
      out_last_o <= s3_last_q;
      out_user_o <= s3_err_q;
    end
  end

`ifndef SYNTHESIS
  a_short_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_user_o |-> out_last_o && out_data_o == '0)
    else $error("too-short result without run end or with nonzero data");
`endif

endmodule

`default_nettype wire

// ===== design/bspline_to_bezier_converter.sv =====
// Uniform cubic B-spline to Bezier converter.
// s_axis: one control point per word, tdata = {y, x} (signed Q16.16), tlast on
//   the final point of a spline. m_axis: one Bezier control point per word,
//   tdata = {y, x}, tlast on the last point of the curve, tuser set on the single
//   all-zero result of a spline with fewer than three points.
// cfg: cfg_data_i = closed_curve, always ready; write only while the block is idle.
// A point is classified on acceptance; a point that completes a segment or ends a
//   short run becomes a job. Jobs wait in a four-entry queue for the arithmetic pipe,
//   which emits one result a cycle while m_axis is not stalled.
// The input rate is set by the single result port: the fourth point yields four
//   results, each later point three. On the last point of a closed curve the front
//   replays the first points, holding s_axis_tready low while it does so and
//   while the queue is full.
// A stalled m_axis freezes the pipe; the queue still takes points until full.
// Reset clears the run state and the closed_curve register; no clearing pass.
`default_nettype none

module bspline_to_bezier_converter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // point_x, point_y
  input  wire logic        s_axis_tlast,   // is_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // bezier_x, bezier_y
  output logic             m_axis_tlast,   // run_end
  output logic [0:0]       m_axis_tuser,   // too_short
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i      // closed_curve
);

  logic           push, full, pop, empty;
  bsbz_pkg::job_t push_job, head_job;

  assign cfg_ready_o = 1'b1;

  bsbz_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_point_i  (bsbz_pkg::point_t'(s_axis_tdata)),
    .in_last_i   (s_axis_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .job_o       (push_job),
    .full_i      (full)
  );

  bsbz_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .head_job_o (head_job),
    .empty_o    (empty)
  );

  bsbz_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_user_o  (m_axis_tuser[0])
  );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW           = bsbz_pkg::CoordW;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned PhaseItems   = 30;
  localparam int unsigned MaxGap       = 19;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t CoordMax = 32'sh7fff_ffff;
  localparam coord_t CoordMin = 32'sh8000_0000;

  typedef struct {
    coord_t x;
    coord_t y;
    bit     run_end;
    bit     too_short;
  } bezier_pt_t;

  class bezier_tracker;
    bit         closed;
    coord_t     win_x[3];
    coord_t     win_y[3];
    coord_t     head_x[3];
    coord_t     head_y[3];
    bit [2:0]   seen;
    bezier_pt_t pending_bezier[$];
    int unsigned bad_count;

    function new();
      closed = 1'b0;
      seen = '0;
      bad_count = 0;
      for (int i = 0; i < 3; i++) begin
        win_x[i] = '0;
        win_y[i] = '0;
        head_x[i] = '0;
        head_y[i] = '0;
      end
    endfunction

    // divide by six, nearest, ties away from zero
    static function longint sixth(longint s);
      if (s >= 0) return (s + 3) / 6;
      return -((-s + 3) / 6);
    endfunction

    function void push_sum(longint sx, longint sy);
      bezier_pt_t pt;
      pt.x = coord_t'(sixth(sx));
      pt.y = coord_t'(sixth(sy));
      pt.run_end = 1'b0;
      pt.too_short = 1'b0;
      pending_bezier.push_back(pt);
    endfunction

    function void shift_in(coord_t px, coord_t py);
      win_x[0] = win_x[1];
      win_x[1] = win_x[2];
      win_x[2] = px;
      win_y[0] = win_y[1];
      win_y[1] = win_y[2];
      win_y[2] = py;
    endfunction

    function void segment_tail(coord_t dx, coord_t dy);
      longint bx, cx, by, cy;
      bx = longint'(win_x[1]);
      cx = longint'(win_x[2]);
      by = longint'(win_y[1]);
      cy = longint'(win_y[2]);
      push_sum(4 * bx + 2 * cx, 4 * by + 2 * cy);
      push_sum(2 * bx + 4 * cx, 2 * by + 4 * cy);
      push_sum(bx + 4 * cx + longint'(dx), by + 4 * cy + longint'(dy));
      shift_in(dx, dy);
    endfunction

    function void segment_full(coord_t dx, coord_t dy);
      push_sum(longint'(win_x[0]) + 4 * longint'(win_x[1]) + longint'(win_x[2]),
               longint'(win_y[0]) + 4 * longint'(win_y[1]) + longint'(win_y[2]));
      segment_tail(dx, dy);
    endfunction

    function void replay_head(int unsigned from);
      for (int unsigned i = from; i < 3; i++) segment_tail(head_x[i], head_y[i]);
    endfunction

    function void take_control_point(coord_t px, coord_t py, bit last);
      int unsigned cnt;
      bezier_pt_t pt;
      cnt = (seen > 3'd4) ? 4 : int'(seen);
      if (cnt < 2) begin
        if (last) begin
          pt.x = '0;
          pt.y = '0;
          pt.run_end = 1'b1;
          pt.too_short = 1'b1;
          pending_bezier.push_back(pt);
          seen = '0;
          return;
        end
        head_x[cnt] = px;
        head_y[cnt] = py;
        shift_in(px, py);
        seen = 3'(cnt + 1);
        return;
      end
      if (cnt == 2) begin
        head_x[2] = px;
        head_y[2] = py;
        shift_in(px, py);
        if (!last) begin
          seen = 3'd3;
          return;
        end
        // three-point run: the first point doubles as the fourth
        segment_full(head_x[0], head_y[0]);
        if (closed) replay_head(1);
      end else begin
        if (cnt == 3) segment_full(px, py);
        else segment_tail(px, py);
        if (!last) begin
          seen = 3'd4;
          return;
        end
        if (closed) replay_head(0);
      end
      pt = pending_bezier.pop_back();
      pt.run_end = 1'b1;
      pending_bezier.push_back(pt);
      seen = '0;
    endfunction

    function void compare_bezier(coord_t x, coord_t y, bit run_end, bit too_short);
      bezier_pt_t want;
      if (pending_bezier.size() == 0) begin
        bad_count++;
        if (bad_count <= ReportLimit)
          $display("unexpected bezier word: x=%h y=%h last=%b short=%b",
                   x, y, run_end, too_short);
        return;
      end
      want = pending_bezier.pop_front();
      if (x !== want.x || y !== want.y || run_end !== want.run_end ||
          too_short !== want.too_short) begin
        bad_count++;
        if (bad_count <= ReportLimit)
          $display("bezier mismatch: x %h/%h y %h/%h last %b/%b short %b/%b (exp/got)",
                   want.x, x, want.y, y, want.run_end, run_end,
                   want.too_short, too_short);
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [63:0]   s_axis_tdata = '0;   // point_x, point_y
  logic          s_axis_tlast = 1'b0; // is_last
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [63:0]   m_axis_tdata;        // bezier_x, bezier_y
  logic          m_axis_tlast;        // run_end
  logic [0:0]    m_axis_tuser;        // too_short
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic          cfg_data_i = 1'b0;   // closed_curve

  bezier_tracker tracker;
  bit            steady = 1'b0;

  bspline_to_bezier_converter u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned draw_gap();
    if (steady) return 0;
    return $urandom_range(0, MaxGap);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return CoordMax;
      1: return CoordMin;
      2: return '0;
      3, 4: return coord_t'($urandom_range(0, 4000)) - 2000;
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic send_point(input coord_t x, input coord_t y, input bit last);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {y, x};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.take_control_point(x, y, last);
  endtask

  task automatic send_spline(input int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_point(rand_coord(), rand_coord(), i == len - 1);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_bezier.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_closed(input bit value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tracker.closed = value;
  endtask

  // result side
  initial begin
    int unsigned gap;
    wait (rst_ni === 1'b1);
    forever begin
      gap = draw_gap();
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      tracker.compare_bezier(m_axis_tdata[CW-1:0], m_axis_tdata[2*CW-1:CW],
                             m_axis_tlast, m_axis_tuser[0]);
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    bit          mode;
    tracker = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // open curves, register still at its reset value
    send_point(CoordMin, CoordMax, 1'b1);
    send_point(CoordMax, CoordMin, 1'b0);
    send_point('0, -32'sd1, 1'b1);
    send_point(CoordMax, CoordMax, 1'b0);
    send_point(CoordMin, CoordMin, 1'b0);
    send_point(CoordMax, CoordMin, 1'b1);
    send_point(CoordMin, CoordMax, 1'b0);
    send_point(CoordMax, CoordMin, 1'b0);
    send_point(CoordMin, CoordMin, 1'b0);
    send_point(CoordMax, CoordMax, 1'b0);
    send_point(-32'sd1, 32'sd1, 1'b1);
    // sums of exactly half a sixth, both signs
    send_point(32'sd1, -32'sd1, 1'b0);
    send_point('0, '0, 1'b0);
    send_point(32'sd2, -32'sd2, 1'b0);
    send_point(32'sd3, -32'sd3, 1'b1);
    drain();

    // closed curves: three points, then four
    write_closed(1'b1);
    send_point(CoordMax, '0, 1'b0);
    send_point(CoordMin, '0, 1'b0);
    send_point('0, CoordMax, 1'b1);
    send_spline(4);
    drain();

    mode = 1'($urandom_range(0, 1));
    for (int unsigned ph = 0; ph < 4; ph++) begin
      steady = (ph == 2);
      write_closed(mode ^ ph[0]);
      sent = 0;
      while (sent < PhaseItems) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) len = $urandom_range(1, 2);
        else if (pick == 1) len = 3;
        else len = $urandom_range(4, 12);
        send_spline(len);
        sent += len;
      end
      drain();
    end

    if (tracker.bad_count == 0 && tracker.pending_bezier.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/bsbz_pkg.sv
design/bsbz_front.sv
design/bsbz_queue.sv
design/bsbz_back.sv
design/bspline_to_bezier_converter.sv
dv/testbench.sv
